FILE: hdl/lzsd_pkg.sv
package lzsd_pkg;

    // History window of the decoder.
    localparam int WIN_AW = 12;
    localparam logic [WIN_AW:0] WIN_SIZE = 13'd4096;

    // Depth of the command queue between parser and copy engine.
    localparam int CMDQ_DEPTH = 4;

    // Command kinds passed from the parser to the copy engine.
    localparam logic [1:0] CMD_NOP  = 2'd0;
    localparam logic [1:0] CMD_LIT  = 2'd1;
    localparam logic [1:0] CMD_COPY = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        lit;
        logic [WIN_AW-1:0] off_m1;
        logic [3:0]        len_raw;
        logic              last;
    } t_cmd;

endpackage

FILE: hdl/lzsd_ram.sv
module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lzsd_front.sv
module lzsd_front
    import lzsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_ITEM = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_flags, n_flags;
    logic [2:0] r_idx, n_idx;
    logic [7:0] r_high, n_high;
    logic       is_token;
    logic       push;
    t_cmd       cmd;

    assign is_token = r_flags[3'd7 - r_idx];

    always_comb begin
        n_phase      = r_phase;
        n_flags      = r_flags;
        n_idx        = r_idx;
        n_high       = r_high;
        push         = i_item.stream_last;
        cmd.kind     = CMD_NOP;
        cmd.lit      = i_item.in_byte;
        cmd.off_m1   = {r_high, i_item.in_byte[7:4]};
        cmd.len_raw  = i_item.in_byte[3:0];
        cmd.last     = i_item.stream_last;
        unique case (r_phase)
            PH_ITEM: begin
                if (is_token) begin
                    n_high  = i_item.in_byte;
                    n_phase = PH_LOW;
                end else begin
                    push     = 1'b1;
                    cmd.kind = CMD_LIT;
                    n_idx    = r_idx + 3'd1;
                    n_phase  = (r_idx == 3'd7) ? PH_FLAG : PH_ITEM;
                end
            end
            PH_LOW: begin
                push     = 1'b1;
                cmd.kind = CMD_COPY;
                n_idx    = r_idx + 3'd1;
                n_phase  = (r_idx == 3'd7) ? PH_FLAG : PH_ITEM;
            end
            default: begin
                n_flags = i_item.in_byte;
                n_idx   = 3'd0;
                n_phase = PH_ITEM;
            end
        endcase
        // The end of a stream drops any half token and restarts the parser.
        if (i_item.stream_last) begin
            n_phase = PH_FLAG;
            n_flags = 8'd0;
            n_idx   = 3'd0;
            n_high  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAG;
            r_flags <= 8'd0;
            r_idx   <= 3'd0;
            r_high  <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_idx   <= n_idx;
            r_high  <= n_high;
        end
    end

    assign o_push = i_accept & push;
    assign o_cmd  = cmd;

endmodule

FILE: hdl/lzsd_cmdq.sv
module lzsd_cmdq
    import lzsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_buf [CMDQ_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_head  = r_buf[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= (r_wr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: hdl/lzsd_back.sv
module lzsd_back
    import lzsd_pkg::*;
#(
    parameter int MIN_MATCH_LEN = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd      i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int LEN_W = $clog2(15 + MIN_MATCH_LEN + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic [WIN_AW-1:0] r_off_m1, n_off_m1;
    logic              r_is_lit, n_is_lit;
    logic [7:0]        r_lit, n_lit;
    logic              r_last, n_last;
    logic [WIN_AW-1:0] r_wp, n_wp;
    logic [WIN_AW:0]   r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;

    logic              out_free;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_off;
    logic [WIN_AW-1:0] rd_addr;
    logic [7:0]        ram_q;
    logic              we;
    logic              ref_ok;
    logic [7:0]        value;

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign o_pop    = (r_state == ST_IDLE) & ~i_empty;
    assign rd_en    = (o_pop & (i_head.kind == CMD_COPY)) | (r_state == ST_RD);
    assign rd_off   = (r_state == ST_IDLE) ? i_head.off_m1 : r_off_m1;
    assign rd_addr  = r_wp - rd_off - WIN_AW'(1);
    assign we       = (r_state == ST_WR) & out_free;
    assign ref_ok   = {1'b0, r_off_m1} < r_cnt;
    assign value    = r_is_lit ? r_lit : (ref_ok ? ram_q : 8'd0);

    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (1 << WIN_AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_off_m1    = r_off_m1;
        n_is_lit    = r_is_lit;
        n_lit       = r_lit;
        n_last      = r_last;
        n_wp        = r_wp;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_item  = r_out_item;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_off_m1 = i_head.off_m1;
                    n_lit    = i_head.lit;
                    n_last   = i_head.last;
                    if (i_head.kind == CMD_LIT) begin
                        n_is_lit = 1'b1;
                        n_rem    = LEN_W'(1);
                        n_state  = ST_WR;
                    end else if (i_head.kind == CMD_COPY) begin
                        n_is_lit = 1'b0;
                        n_rem    = LEN_W'(i_head.len_raw) + LEN_W'(MIN_MATCH_LEN);
                        n_state  = ST_WR;
                    end else if (i_head.last) begin
                        n_wp  = '0;
                        n_cnt = '0;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out_item.out_byte = value;
                    n_out_item.run_last = (r_rem == LEN_W'(1));
                    n_wp                = r_wp + WIN_AW'(1);
                    n_cnt               = (r_cnt == WIN_SIZE) ? r_cnt : r_cnt + 13'd1;
                    n_rem               = r_rem - LEN_W'(1);
                    if (r_rem == LEN_W'(1)) begin
                        n_state = ST_IDLE;
                        if (r_last) begin
                            n_wp  = '0;
                            n_cnt = '0;
                        end
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rem       <= '0;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rem       <= n_rem;
            r_wp        <= n_wp;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off_m1   <= n_off_m1;
        r_is_lit   <= n_is_lit;
        r_lit      <= n_lit;
        r_last     <= n_last;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= WIN_SIZE)
        else $error("produced count above window size");

    a_read_before_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) && !r_is_lit && !$stable(r_state) |-> $past(rd_en))
        else $error("copy byte written without a history read");

    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_rem != '0))
        else $error("copy engine busy with no bytes left");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we && (r_rem == LEN_W'(1)) |=> r_out_item.run_last)
        else $error("final byte of a command not marked");

endmodule

FILE: hdl/lzss_stream_decoder_top.sv
// With the copy engine idle, a literal or the first byte of a token goes from the input
// transfer that completes it through the queue and engine state to the output register.
// The engine writes a literal, copies a token of L bytes by a history read and a write
// per byte, and takes a bare stream end in idle; inputs transfer while the queue has room.
// Reset (synchronous, active low) clears the parser, queue, pointers and output valid;
// the history RAM is not cleared, since the produced count guards every read of it.
module lzss_stream_decoder_top
    import lzsd_pkg::*;
#(
    parameter int MIN_MATCH_LEN = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // An input transfer happens whenever the queue can take one more command.
    // This is slightly conservative, since flag bytes push nothing, but it keeps
    // the stall free of any dependence on the payload.
    logic in_accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid & ~q_full;

    // The front end parses flag bytes and tokens into literal, copy and
    // stream-end commands.
    lzsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // The queue decouples the parser from the byte-at-a-time copy engine.
    lzsd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // The back end owns the history window and the output register. A stream-end
    // command rewinds the write pointer and produced count after its bytes.
    lzsd_back #(
        .MIN_MATCH_LEN (MIN_MATCH_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: dv/lzss_stream_decoder_top_tb.sv
`timescale 1ns / 100ps

module lzss_stream_decoder_top_tb
    import lzsd_pkg::*;
();

    localparam int MATCH_MIN    = 3;
    localparam int RAND_ITEMS   = 125;
    localparam int WATCHDOG_CYC = 2000;
    localparam int DRAIN_CYC    = 40;

    // Parser phases of the decoder. The spare code behaves like a flag byte phase.
    typedef enum logic [1:0] {
        EXPECT_FLAG = 2'd0,
        EXPECT_ITEM = 2'd1,
        EXPECT_LOW  = 2'd2,
        PHASE_SPARE = 2'd3
    } t_phase;

    // A hand-written expectation: n output bytes, all equal to v.
    typedef struct {
        bit         typed;
        int         n;
        logic [7:0] v;
    } t_expect;

    typedef struct {
        t_in_item item;
        t_expect  want;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    lzss_stream_decoder_top #(
        .MIN_MATCH_LEN(MATCH_MIN)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    // Decoder state as the testbench sees it. The history is only read at
    // distances that the produced count shows to be written.
    t_phase      phase    = EXPECT_FLAG;
    logic [7:0]  flags    = '0;
    logic [3:0]  fidx     = '0;
    logic [7:0]  hi_byte  = '0;
    logic [7:0]  hist [0:4095];
    logic [11:0] wr_ptr   = '0;
    logic [12:0] made_cnt = '0;

    // Bytes decoded from the most recent input transfer.
    t_out_item step_out[$];
    // Output bytes still owed by the block, oldest first.
    t_out_item owed_bytes[$];
    // Hand-written expectations, one per input item in flight.
    t_expect   row_want[$];

    int  err_cnt  = 0;
    int  idle_cyc = 0;
    bit  no_idle  = 1'b0;

    function automatic void emit_byte(input logic [7:0] b);
        hist[wr_ptr] = b;
        wr_ptr = wr_ptr + 12'd1;
        if (made_cnt < WIN_SIZE) begin
            made_cnt = made_cnt + 13'd1;
        end
        step_out.push_back('{b, 1'b0});
    endfunction

    function automatic void close_item();
        fidx = fidx + 4'd1;
        if (fidx >= 4'd8) begin
            fidx  = '0;
            phase = EXPECT_FLAG;
        end else begin
            phase = EXPECT_ITEM;
        end
    endfunction

    // Advances the decoder state by one compressed byte and leaves the
    // decompressed bytes it causes in step_out.
    function automatic void decode_byte(input t_in_item it);
        logic [15:0] word;
        logic [12:0] back_off;
        logic [11:0] rd_idx;
        logic [7:0]  v;
        int          cnt;
        int          i;
        step_out.delete();
        case (phase)
            EXPECT_ITEM: begin
                if (flags[3'd7 - fidx[2:0]]) begin
                    hi_byte = it.in_byte;
                    phase   = EXPECT_LOW;
                end else begin
                    emit_byte(it.in_byte);
                    close_item();
                end
            end
            EXPECT_LOW: begin
                word     = {hi_byte, it.in_byte};
                back_off = {1'b0, word[15:4]} + 13'd1;
                cnt      = int'(word[3:0]) + MATCH_MIN;
                // Bytes are copied one at a time, so an overlapping copy
                // repeats what it has just written.
                for (i = 0; i < cnt; i++) begin
                    rd_idx = wr_ptr - back_off[11:0];
                    v = (back_off <= made_cnt) ? hist[rd_idx] : 8'h00;
                    emit_byte(v);
                end
                close_item();
            end
            default: begin
                flags = it.in_byte;
                fidx  = '0;
                phase = EXPECT_ITEM;
            end
        endcase
        if (step_out.size() != 0) begin
            step_out[step_out.size() - 1].run_last = 1'b1;
        end
        // The end of a stream drops any pending token high byte and starts over.
        if (it.stream_last) begin
            phase    = EXPECT_FLAG;
            flags    = '0;
            fidx     = '0;
            hi_byte  = '0;
            wr_ptr   = '0;
            made_cnt = '0;
        end
    endfunction

    // Output stall: random with a chance of about 17 in a hundred, except in the quiet stretch.
    always @(negedge i_clk) begin
        i_out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 17);
    end

    // Everything is sampled at the rising edge, before the block's registers move.
    always @(posedge i_clk) begin
        t_expect   w;
        t_out_item got;
        int        i;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                w = row_want.pop_front();
                decode_byte(i_in_item);
                if (w.typed) begin
                    for (i = 0; i < w.n; i++) begin
                        owed_bytes.push_back('{w.v, (i == w.n - 1)});
                    end
                end else begin
                    foreach (step_out[i]) begin
                        owed_bytes.push_back(step_out[i]);
                    end
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (owed_bytes.size() == 0) begin
                    $error("unexpected output transfer, out_byte %h", o_out_item.out_byte);
                    err_cnt++;
                end else begin
                    got = owed_bytes.pop_front();
                    if (o_out_item.out_byte !== got.out_byte) begin
                        $error("out_byte: expected %h, actual %h",
                               got.out_byte, o_out_item.out_byte);
                        err_cnt++;
                    end
                    if (o_out_item.run_last !== got.run_last) begin
                        $error("run_last: expected %b, actual %b",
                               got.run_last, o_out_item.run_last);
                        err_cnt++;
                    end
                end
            end
            // The watchdog only counts cycles in which neither side moves a transfer.
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cyc = 0;
            end else begin
                idle_cyc++;
            end
            if (idle_cyc >= WATCHDOG_CYC) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Presents one input item at a falling edge and returns at the falling edge
    // after its transfer. The sender may idle first.
    task automatic send_item(input t_in_item it, input t_expect want);
        while (!no_idle && $urandom_range(0, 99) < 17) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        row_want.push_back(want);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    initial begin
        t_row        dir_tab [23];
        t_in_item    strm[$];
        t_in_item    stim[$];
        t_expect     none;
        logic [7:0]  flg;
        logic [11:0] off;
        logic [3:0]  ln;
        int          g;
        int          j;
        int          k;
        int          cut;
        int          plain_cnt;

        none = '{1'b0, 0, 8'h00};

        // Directed stream. Rows with a typed expectation can be read off directly;
        // the others go through the predictor.
        dir_tab = '{
            // Flag byte: token, token, literal, token, then four literals.
            '{'{8'hD0, 1'b0}, '{1'b1, 0, 8'h00}},
            // Largest offset and length with nothing produced yet: all zeros.
            '{'{8'hFF, 1'b0}, '{1'b1, 0, 8'h00}},
            '{'{8'hFF, 1'b0}, '{1'b1, 18, 8'h00}},
            // Smallest offset and length, copying the zeros just made.
            '{'{8'h00, 1'b0}, '{1'b1, 0, 8'h00}},
            '{'{8'h00, 1'b0}, '{1'b1, 3, 8'h00}},
            '{'{8'hFF, 1'b0}, '{1'b1, 1, 8'hFF}},
            // Offset one, longest length: the overlapping copy repeats the literal.
            '{'{8'h00, 1'b0}, '{1'b1, 0, 8'h00}},
            '{'{8'h0F, 1'b0}, '{1'b1, 18, 8'hFF}},
            '{'{8'h00, 1'b0}, '{1'b1, 1, 8'h00}},
            '{'{8'hA5, 1'b0}, '{1'b1, 1, 8'hA5}},
            '{'{8'h5A, 1'b0}, '{1'b1, 1, 8'h5A}},
            '{'{8'h3C, 1'b0}, '{1'b1, 1, 8'h3C}},
            // Second flag byte of the same stream: all tokens.
            '{'{8'hFF, 1'b0}, '{1'b1, 0, 8'h00}},
            '{'{8'h00, 1'b0}, '{1'b1, 0, 8'h00}},
            '{'{8'h41, 1'b0}, none},
            // Offset 292 with only 48 bytes produced gives zeros.
            '{'{8'h12, 1'b0}, '{1'b1, 0, 8'h00}},
            '{'{8'h34, 1'b0}, '{1'b1, 7, 8'h00}},
            // Stream ends on a token high byte, which is dropped.
            '{'{8'hAB, 1'b1}, '{1'b1, 0, 8'h00}},
            '{'{8'h40, 1'b0}, '{1'b1, 0, 8'h00}},
            '{'{8'h81, 1'b0}, '{1'b1, 1, 8'h81}},
            // A copy that starts before the stream and runs into it; the stream ends here.
            '{'{8'h00, 1'b0}, '{1'b1, 0, 8'h00}},
            '{'{8'h10, 1'b1}, none},
            // A stream that is only a flag byte.
            '{'{8'h55, 1'b1}, '{1'b1, 0, 8'h00}}
        };

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            send_item(dir_tab[k].item, dir_tab[k].want);
        end

        // The sender holds off here until the block has delivered everything.
        i_in_valid <= 1'b0;
        while (owed_bytes.size() != 0 || row_want.size() != 0) begin
            @(negedge i_clk);
        end

        // Random streams. Most are well formed with random content, some are cut
        // short anywhere (possibly inside a token), and a few are plain noise.
        plain_cnt = 0;
        while (plain_cnt < RAND_ITEMS) begin
            strm.delete();
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, 12);
                for (j = 0; j < cut; j++) begin
                    strm.push_back('{8'($urandom), ($urandom_range(0, 5) == 0)});
                end
                plain_cnt += cut;
            end else begin
                for (g = $urandom_range(1, 3); g > 0; g--) begin
                    flg = 8'($urandom);
                    strm.push_back('{flg, 1'b0});
                    for (j = 0; j < 8; j++) begin
                        if (flg[7 - j]) begin
                            off = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 15))
                                                              : 12'($urandom);
                            ln  = 4'($urandom);
                            strm.push_back('{off[11:4], 1'b0});
                            strm.push_back('{{off[3:0], ln}, 1'b0});
                        end else begin
                            strm.push_back('{8'($urandom), 1'b0});
                        end
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    cut  = $urandom_range(0, strm.size() - 1);
                    strm = strm[0:cut];
                end
                plain_cnt += strm.size();
            end
            strm[strm.size() - 1].stream_last = 1'b1;
            foreach (strm[j]) begin
                stim.push_back(strm[j]);
            end
        end

        for (k = 0; k < stim.size(); k++) begin
            // A stretch in which the sender never idles and the output is never stalled.
            no_idle = (k >= 40 && k < 100);
            send_item(stim[k], none);
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        while (owed_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        // Any stray output after the last expected byte is caught in these cycles.
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (err_cnt == 0 && owed_bytes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
